@@ design/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, constants and the character-to-sextet map.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned FifoDepthDefault = 4;

    localparam logic [7:0] PadChar = 8'h3D;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_CHAR   = 2'd1,
        ERR_LENGTH = 2'd2
    } err_kind_t;

    // One decoded group: up to three bytes, closing flag and error code.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
        err_kind_t       err;
    } grp_t;

    // Return {valid, sextet}.
    function automatic logic [6:0] to_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

@@ design/b64d_in_if.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder character channel
// Valid/ready channel carrying one encoded character and its closing flag.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_message;

    modport source (output valid, output character, output end_of_message, input ready);
    modport sink   (input valid, input character, input end_of_message, output ready);
endinterface

@@ design/b64d_out_if.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder byte channel
// Valid/ready channel carrying one decoded byte, closing flag and error code.
// ----------------------------------------------------------------------------
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       message_end;
    logic [1:0] error_kind;

    modport source (output valid, output byte_out, output message_end,
                    output error_kind, input ready);
    modport sink   (input valid, input byte_out, input message_end,
                    input error_kind, output ready);
endinterface

@@ design/base64_decoder_with_checks_unit.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder with checks
// Streaming standard-alphabet base64 decoder with length and character checks.
//
// in_ch takes one encoded character per beat, end_of_message set on the last
// character of a message. out_ch gives one decoded byte per beat; the final
// beat of a message has message_end set. On an error the message closes with
// a single beat of byte 0 and error_kind set (length error over character
// error); bytes sent earlier in that message stand and are to be discarded.
// A character is taken every cycle while the group queue has room; a byte
// leaves every cycle while out_ch is ready, so four characters in give three
// bytes out without stalling. After a group's closing character is taken, its
// bytes pass the queue and then the output register. When out_ch stalls, the
// output register holds its beat and the queue fills; in_ch drops ready only
// once all FifoDepth group records are waiting. Reset empties the queue, clears
// the output valid and returns the group position and error flags to zero.
// ----------------------------------------------------------------------------
module base64_decoder_with_checks_unit
    import b64d_pkg::*;
#(
    parameter int unsigned FifoDepth = FifoDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    b64d_in_if.sink    in_ch,
    b64d_out_if.source out_ch
);

    logic fire;
    logic push;
    logic pop;
    logic full;
    logic empty;
    grp_t grp_in;
    grp_t grp_head;

    assign in_ch.ready = !full;
    assign fire        = in_ch.valid && !full;

    b64d_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .character      (in_ch.character),
        .end_of_message (in_ch.end_of_message),
        .push           (push),
        .grp            (grp_in)
    );

    b64d_queue #(
        .Depth (FifoDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (grp_in),
        .pop     (pop),
        .rd_data (grp_head),
        .full    (full),
        .empty   (empty)
    );

    b64d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (grp_head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ design/b64d_front.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, tracks group position and padding, and forms
// one group record per error-free group or message close.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] character,
    input  logic       end_of_message,
    output logic       push,
    output grp_t       grp
);

    logic [1:0]      pos_reg, pos_next;
    logic            third_pad_reg, third_pad_next;
    logic            pend_reg, pend_next;
    logic [2:0][5:0] held_reg;

    logic [6:0] sx;
    logic       pad;
    logic       bad;
    logic [1:0] nb;
    logic [5:0] s3;
    logic       pend_eff;
    err_kind_t  err;

    assign sx  = to_sextet(character);
    assign pad = (character == PadChar);

    always_comb
    begin
        bad = 1'b0;
        nb  = 2'd0;
        s3  = 6'd0;
        third_pad_next = third_pad_reg;
        if (!pend_reg)
        begin
            case (pos_reg)
                2'd0, 2'd1:
                begin
                    bad = !sx[6];
                end
                2'd2:
                begin
                    if (sx[6])
                    begin
                        third_pad_next = 1'b0;
                    end
                    else if (pad)
                    begin
                        third_pad_next = 1'b1;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    if (third_pad_reg)
                    begin
                        if (pad && end_of_message) nb = 2'd1;
                        else bad = 1'b1;
                    end
                    else if (sx[6])
                    begin
                        s3 = sx[5:0];
                        nb = 2'd3;
                    end
                    else if (pad && end_of_message)
                    begin
                        nb = 2'd2;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
            endcase
            if (bad) nb = 2'd0;
        end
        if (pos_reg == 2'd3 || end_of_message) third_pad_next = 1'b0;
        pend_eff  = pend_reg | bad;
        pend_next = end_of_message ? 1'b0 : pend_eff;
        pos_next  = end_of_message ? 2'd0 : pos_reg + 2'd1;
    end

    always_comb
    begin
        if (pos_reg != 2'd3) err = ERR_LENGTH;
        else if (pend_eff)   err = ERR_CHAR;
        else                 err = ERR_NONE;
    end

    always_comb
    begin
        grp.bytes[0] = {held_reg[0], held_reg[1][5:4]};
        grp.bytes[1] = {held_reg[1][3:0], held_reg[2][5:2]};
        grp.bytes[2] = {held_reg[2][1:0], s3};
        grp.count    = nb;
        grp.last     = end_of_message;
        grp.err      = ERR_NONE;
        if (end_of_message && (err != ERR_NONE || nb == 2'd0))
        begin
            grp.bytes = '0;
            grp.count = 2'd1;
            grp.err   = err;
        end
    end

    assign push = fire && (end_of_message || nb != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            third_pad_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !pend_reg && pos_reg != 2'd3 && sx[6])
        begin
            held_reg[pos_reg] <= sx[5:0];
        end
    end

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_message |=> pos_reg == 2'd0 && !pend_reg && !third_pad_reg)
        else $error("front state not cleared after message close");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> grp.count != 2'd0 && (grp.err == ERR_NONE || grp.count == 2'd1))
        else $error("malformed group record");

endmodule

@@ design/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder group queue
// Short register queue of group records between front and back end.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int unsigned Depth = FifoDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  grp_t wr_data,
    input  logic pop,
    output grp_t rd_data,
    output logic full,
    output logic empty
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

    grp_t          mem_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

@@ design/b64d_back.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Walks the head group record one byte per beat into the output register.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  grp_t head,
    input  logic empty,
    output logic pop,
    b64d_out_if.source out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    err_kind_t  err_reg;
    logic       load;
    logic       take;
    logic       last_beat;

    assign load      = !ov_reg || out_ch.ready;
    assign take      = load && !empty;
    assign last_beat = (idx_reg == head.count - 2'd1);
    assign pop       = take && last_beat;

    always_comb
    begin
        idx_next = idx_reg;
        if (take) idx_next = last_beat ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load) ov_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= head.bytes[idx_reg];
            end_reg  <= head.last && last_beat;
            err_reg  <= head.err;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.byte_out    = byte_reg;
    assign out_ch.message_end = end_reg;
    assign out_ch.error_kind  = err_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> !empty && idx_reg < head.count)
        else $error("beat index outside head record");

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && err_reg != ERR_NONE |-> byte_reg == 8'd0 && end_reg)
        else $error("error beat not closing or not zero");

endmodule
